// File: design/mbce_pkg.sv
// mbce_pkg: shared types and constants of the monochrome bitmap color expander.
// Holds field widths, register index codes, reset values and the queue word layout.
// No dependencies.
package mbce_pkg;

   // field widths fixed by the data format
   localparam int MASK_W   = 8;
   localparam int COLOR_W  = 16;
   localparam int WIDTH_W  = 10;
   localparam int HEIGHT_W = 11;
   localparam int SPLIT_W  = 10;
   localparam int ROW_W    = HEIGHT_W;
   localparam int COL_W    = WIDTH_W;
   localparam int PIX_W    = 3;               // pixel index inside one byte
   localparam int CNT_W    = PIX_W + 1;       // pixel count of one byte, 1..8

   localparam int BAND_ROWS     = 4;
   localparam int TOP_BIT       = 7;
   localparam int BITS_PER_BYTE = 8;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOREGROUND_COLOR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_BACKGROUND    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_BACKGROUND = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_ROW         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_COLOR     = 3'd6;

   // register reset values
   localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 10'd8;
   localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 11'd1;
   localparam logic [COLOR_W-1:0]  RST_FOREGROUND   = 16'hFFFF;
   localparam logic [COLOR_W-1:0]  RST_TOP_BG       = 16'h0000;
   localparam logic [COLOR_W-1:0]  RST_BOTTOM_BG    = 16'h0000;
   localparam logic [SPLIT_W-1:0]  RST_SPLIT_ROW    = 10'd1023;
   localparam logic [COLOR_W-1:0]  RST_DIVIDER      = 16'h0000;

   // queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [WIDTH_W-1:0]  image_width;
      logic [HEIGHT_W-1:0] image_height;
      logic [COLOR_W-1:0]  foreground_color;
      logic [COLOR_W-1:0]  top_background;
      logic [COLOR_W-1:0]  bottom_background;
      logic [SPLIT_W-1:0]  split_row;
      logic [COLOR_W-1:0]  divider_color;
   } cfg_type;

   // one classified byte: colors already resolved for clear and set bits
   typedef struct packed {
      logic [MASK_W-1:0]  mask;
      logic [PIX_W-1:0]   last_idx;
      logic [COLOR_W-1:0] clear_color;
      logic [COLOR_W-1:0] set_color;
      logic               row_done;
      logic               frame_done;
   } entry_type;

endpackage

// File: design/mbce_req_if.sv
// mbce_req_if: input channel carrying one image byte per word.
// Depends on mbce_pkg.
interface mbce_req_if
   import mbce_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] mask_byte;
   logic              frame_start;

   modport source (output valid, output mask_byte, output frame_start, input ready);
   modport sink   (input valid, input mask_byte, input frame_start, output ready);
endinterface

// File: design/mbce_rsp_if.sv
// mbce_rsp_if: result channel carrying one RGB565 pixel per word with its flags.
// Depends on mbce_pkg.
interface mbce_rsp_if
   import mbce_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] pixel_color;
   logic               last_of_byte;
   logic               row_end;
   logic               frame_end;

   modport source (output valid, output pixel_color, output last_of_byte,
                   output row_end, output frame_end, input ready);
   modport sink   (input valid, input pixel_color, input last_of_byte,
                   input row_end, input frame_end, output ready);
endinterface

// File: design/mbce_front.sv
// mbce_front: accepts image bytes, tracks column and row, classifies each byte.
// Depends on mbce_pkg and mbce_req_if; pushes entry_type words into the queue.
module mbce_front
   import mbce_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   mbce_req_if.sink   req_ch,
   input  logic       queue_full,
   output logic       push,
   output entry_type  push_entry
);

   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [WIDTH_W-1:0]  width;
   logic [HEIGHT_W-1:0] height;
   logic [COL_W-1:0]    col0, col1, rem;
   logic [ROW_W-1:0]    row0, row1;
   logic [CNT_W-1:0]    count;
   logic                row_done, frame_done, in_band;
   logic [COLOR_W-1:0]  bg;

   // clamp geometry into its legal range
   always_comb begin
      if (cfg.image_width == '0)
         width = WIDTH_W'(1);
      else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
         width = WIDTH_W'(MAX_WIDTH);
      else
         width = cfg.image_width;

      if (cfg.image_height == '0)
         height = HEIGHT_W'(1);
      else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
         height = HEIGHT_W'(MAX_HEIGHT);
      else
         height = cfg.image_height;
   end

   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   // position of this byte and its classification
   always_comb begin
      col0 = req_ch.frame_start ? '0 : col_ff;
      row0 = req_ch.frame_start ? '0 : row_ff;
      col1 = (col0 >= width) ? '0 : col0;
      row1 = (row0 >= height) ? '0 : row0;

      rem      = width - col1;
      row_done = rem <= COL_W'(BITS_PER_BYTE);
      count    = row_done ? rem[CNT_W-1:0] : CNT_W'(BITS_PER_BYTE);
      frame_done = row_done &&
                   (({1'b0, row1} + (ROW_W+1)'(1)) >= {1'b0, height});

      in_band = ({1'b0, row1} >= {2'b00, cfg.split_row}) &&
                ({1'b0, row1} < ({2'b00, cfg.split_row} + (ROW_W+1)'(BAND_ROWS)));
      bg = (row1 < {1'b0, cfg.split_row}) ? cfg.top_background : cfg.bottom_background;

      push_entry.mask        = req_ch.mask_byte;
      push_entry.last_idx    = PIX_W'(count - CNT_W'(1));
      push_entry.clear_color = in_band ? cfg.divider_color : bg;
      push_entry.set_color   = in_band ? cfg.divider_color : cfg.foreground_color;
      push_entry.row_done    = row_done;
      push_entry.frame_done  = frame_done;

      // counters after this byte
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (row_done) begin
            col_in = '0;
            row_in = frame_done ? '0 : row1 + ROW_W'(1);
         end else begin
            col_in = col1 + COL_W'(count);
            row_in = row1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: design/mbce_queue.sv
// mbce_queue: short first-in first-out queue of classified bytes.
// Depends on mbce_pkg; sits between mbce_front and mbce_back.
module mbce_queue
   import mbce_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output entry_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   assign full  = fill_ff == FILL_W'(QUEUE_DEPTH);
   assign empty = fill_ff == '0;
   assign head  = slot_ff[rd_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push)
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (pop)
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop)
         fill_in = fill_ff + FILL_W'(1);
      else if (pop && !push)
         fill_in = fill_ff - FILL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ff] <= push_entry;
   end

endmodule

// File: design/mbce_back.sv
// mbce_back: expands the queue head into one pixel word per cycle while rsp_ch is ready.
// Depends on mbce_pkg and mbce_rsp_if; output register decouples the result side.
module mbce_back
   import mbce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        empty,
   input  entry_type   head,
   output logic        pop,
   mbce_rsp_if.source  rsp_ch
);

   logic [PIX_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               lob_ff, lob_in;
   logic               row_end_ff, row_end_in;
   logic               frame_end_ff, frame_end_in;
   logic               load, last, pix_bit;

   // next pixel from the head entry
   always_comb begin
      load    = !empty && (!valid_ff || rsp_ch.ready);
      last    = idx_ff == head.last_idx;
      pix_bit = head.mask[PIX_W'(TOP_BIT) - idx_ff];
      pop     = load && last;

      idx_in = idx_ff;
      if (load)
         idx_in = last ? '0 : idx_ff + PIX_W'(1);

      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp_ch.ready)
         valid_in = 1'b0;

      color_in     = pix_bit ? head.set_color : head.clear_color;
      lob_in       = last;
      row_end_in   = last && head.row_done;
      frame_end_in = last && head.frame_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load) begin
         color_ff     <= color_in;
         lob_ff       <= lob_in;
         row_end_ff   <= row_end_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.pixel_color  = color_ff;
   assign rsp_ch.last_of_byte = lob_ff;
   assign rsp_ch.row_end      = row_end_ff;
   assign rsp_ch.frame_end    = frame_end_ff;

endmodule

// File: design/mono_bitmap_color_expander.sv
// Path: a byte is held in a queue slot, then each pixel word is registered at the output.
// Throughput: one pixel word per cycle while rsp_ch is ready; a full byte gives 8
//   words, a row's last byte one per pixel; the pixel serializer in mbce_back sets this.
// A two-word queue lets bytes be accepted while earlier pixels still drain.
// Reset (synchronous, active high) clears counters, queue and output valid and
//   restores the configuration registers to their defaults.
module mono_bitmap_color_expander
   import mbce_pkg::*;
#(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   mbce_req_if.sink              req_ch,
   mbce_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   entry_type push_entry, head;
   logic      push, pop, full, empty;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:       cfg_in.image_width       = csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:      cfg_in.image_height      = csr_wdata[HEIGHT_W-1:0];
            CSR_FOREGROUND_COLOR:  cfg_in.foreground_color  = csr_wdata[COLOR_W-1:0];
            CSR_TOP_BACKGROUND:    cfg_in.top_background    = csr_wdata[COLOR_W-1:0];
            CSR_BOTTOM_BACKGROUND: cfg_in.bottom_background = csr_wdata[COLOR_W-1:0];
            CSR_SPLIT_ROW:         cfg_in.split_row         = csr_wdata[SPLIT_W-1:0];
            CSR_DIVIDER_COLOR:     cfg_in.divider_color     = csr_wdata[COLOR_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width       <= RST_IMAGE_WIDTH;
         cfg_ff.image_height      <= RST_IMAGE_HEIGHT;
         cfg_ff.foreground_color  <= RST_FOREGROUND;
         cfg_ff.top_background    <= RST_TOP_BG;
         cfg_ff.bottom_background <= RST_BOTTOM_BG;
         cfg_ff.split_row         <= RST_SPLIT_ROW;
         cfg_ff.divider_color     <= RST_DIVIDER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mbce_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   mbce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   mbce_back u_back (
      .clock  (clock),
      .reset  (reset),
      .empty  (empty),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// File: design/mbce_checker.sv
// mbce_checker: port-level assertions on the result channel of the expander.
// Depends on nothing but the top level's ports; bound to mono_bitmap_color_expander.
module mbce_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic last_of_byte,
   input logic row_end,
   input logic frame_end
);

   // no word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // row end only closes a byte
   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && row_end) |-> last_of_byte)
      else $error("row_end without last_of_byte");

   // frame end only closes a row
   a_frame_end_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && frame_end) |-> row_end)
      else $error("frame_end without row_end");

   // a stalled word stays up
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result word dropped while stalled");

endmodule

bind mono_bitmap_color_expander mbce_checker u_mbce_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .last_of_byte (rsp_ch.last_of_byte),
   .row_end      (rsp_ch.row_end),
   .frame_end    (rsp_ch.frame_end)
);
